[hdl/bfs_path_label_tracer_top_assert.svh]
// Assertion macros used by the path tracer datapath.
`ifndef BFS_PATH_LABEL_TRACER_TOP_ASSERT_SVH
`define BFS_PATH_LABEL_TRACER_TOP_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define BPLT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define BPLT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/bplt_pkg.sv]
// Package with word types, operation codes and constants of the path tracer.
`timescale 1ns / 1ps
package bplt_pkg;

    localparam int MAX_NODES_DEF = 4096;
    localparam int MAX_EDGES_DEF = 16384;
    localparam int MAX_PATH_DEF  = 64;

    localparam logic [12:0] NODE_COUNT_RST = 13'd4096;

    // Request types
    localparam logic [1:0] REQ_OFFSET = 2'd0;
    localparam logic [1:0] REQ_EDGE   = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_CHAR    = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_UNREACH = 2'd2;
    localparam logic [1:0] ST_LONG    = 2'd3;

    // Datapath operations
    localparam logic [4:0] OP_NONE   = 5'd0;
    localparam logic [4:0] OP_LOAD   = 5'd1;
    localparam logic [4:0] OP_QLATCH = 5'd2;
    localparam logic [4:0] OP_CLEAR  = 5'd3;
    localparam logic [4:0] OP_SEED   = 5'd4;
    localparam logic [4:0] OP_DEQ    = 5'd5;
    localparam logic [4:0] OP_ULAT   = 5'd6;
    localparam logic [4:0] OP_OFFA   = 5'd7;
    localparam logic [4:0] OP_OFFE   = 5'd8;
    localparam logic [4:0] OP_ESCAN  = 5'd9;
    localparam logic [4:0] OP_EV     = 5'd10;
    localparam logic [4:0] OP_ES     = 5'd11;
    localparam logic [4:0] OP_TTOP   = 5'd12;
    localparam logic [4:0] OP_EINIT  = 5'd13;
    localparam logic [4:0] OP_TPAR   = 5'd14;
    localparam logic [4:0] OP_THIT   = 5'd15;
    localparam logic [4:0] OP_TPUSH  = 5'd16;
    localparam logic [4:0] OP_ERD    = 5'd17;
    localparam logic [4:0] OP_EOUT   = 5'd18;
    localparam logic [4:0] OP_SOUT   = 5'd19;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [14:0] load_index;
        logic [14:0] offset_value;
        logic [11:0] edge_target;
        logic [7:0]  edge_label;
        logic [11:0] goal_node;
    } in_word_t;

    typedef struct packed {
        logic [7:0] label_char;
        logic [1:0] status;
        logic       last;
    } out_word_t;

    typedef struct packed {
        logic [4:0] op;
        logic [1:0] st;
    } cmd_t;

    typedef struct packed {
        logic chk_bad;
        logic chk_same;
        logic clr_done;
        logic q_empty;
        logic edge_more;
        logic v_bad;
        logic v_seen;
        logic v_goal;
        logic at_start;
        logic hops_full;
        logic scan_hit;
        logic e_zero;
        logic out_free;
    } stat_t;

endpackage

[hdl/bplt_ctrl.sv]
// Sequencer that accepts table loads and steps the search, trace-back and emit phases of a query.
`timescale 1ns / 1ps
module bplt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [1:0]      in_req,
    output logic            in_ready,
    input  bplt_pkg::stat_t stat,
    output bplt_pkg::cmd_t  cmd
);
    import bplt_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CHECK = 5'd1;
    localparam logic [4:0] S_CLEAR = 5'd2;
    localparam logic [4:0] S_SEED  = 5'd3;
    localparam logic [4:0] S_DEQ   = 5'd4;
    localparam logic [4:0] S_ULAT  = 5'd5;
    localparam logic [4:0] S_OFFA  = 5'd6;
    localparam logic [4:0] S_OFFE  = 5'd7;
    localparam logic [4:0] S_ESCAN = 5'd8;
    localparam logic [4:0] S_EV    = 5'd9;
    localparam logic [4:0] S_ES    = 5'd10;
    localparam logic [4:0] S_TTOP  = 5'd11;
    localparam logic [4:0] S_TPAR  = 5'd12;
    localparam logic [4:0] S_TOFFA = 5'd13;
    localparam logic [4:0] S_TOFFE = 5'd14;
    localparam logic [4:0] S_TSCAN = 5'd15;
    localparam logic [4:0] S_TCHK  = 5'd16;
    localparam logic [4:0] S_TPUSH = 5'd17;
    localparam logic [4:0] S_ERD   = 5'd18;
    localparam logic [4:0] S_EOUT  = 5'd19;
    localparam logic [4:0] S_SOUT  = 5'd20;

    logic [4:0] state_reg, state_next;
    logic [1:0] st_reg, st_next;

    // Pick the next state and the datapath operation
    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        in_ready   = 1'b0;
        cmd.op     = OP_NONE;
        cmd.st     = st_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (in_req)
                        REQ_OFFSET, REQ_EDGE: cmd.op = OP_LOAD;
                        REQ_QUERY:
                        begin
                            cmd.op     = OP_QLATCH;
                            state_next = S_CHECK;
                        end
                        default: cmd.op = OP_NONE;
                    endcase
                end
            end
            S_CHECK:
            begin
                if (stat.chk_bad)
                begin
                    st_next    = ST_UNREACH;
                    state_next = S_SOUT;
                end
                else if (stat.chk_same)
                begin
                    st_next    = ST_EMPTY;
                    state_next = S_SOUT;
                end
                else
                    state_next = S_CLEAR;
            end
            S_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (stat.clr_done)
                    state_next = S_SEED;
            end
            S_SEED:
            begin
                cmd.op     = OP_SEED;
                state_next = S_DEQ;
            end
            S_DEQ:
            begin
                if (stat.q_empty)
                begin
                    st_next    = ST_UNREACH;
                    state_next = S_SOUT;
                end
                else
                begin
                    cmd.op     = OP_DEQ;
                    state_next = S_ULAT;
                end
            end
            S_ULAT:
            begin
                cmd.op     = OP_ULAT;
                state_next = S_OFFA;
            end
            S_OFFA:
            begin
                cmd.op     = OP_OFFA;
                state_next = S_OFFE;
            end
            S_OFFE:
            begin
                cmd.op     = OP_OFFE;
                state_next = S_ESCAN;
            end
            S_ESCAN:
            begin
                if (stat.edge_more)
                begin
                    cmd.op     = OP_ESCAN;
                    state_next = S_EV;
                end
                else
                    state_next = S_DEQ;
            end
            S_EV:
            begin
                cmd.op     = OP_EV;
                state_next = stat.v_bad ? S_ESCAN : S_ES;
            end
            S_ES:
            begin
                if (stat.v_seen)
                    state_next = S_ESCAN;
                else
                begin
                    cmd.op     = OP_ES;
                    state_next = stat.v_goal ? S_TTOP : S_ESCAN;
                end
            end
            S_TTOP:
            begin
                if (stat.at_start)
                begin
                    cmd.op     = OP_EINIT;
                    state_next = S_ERD;
                end
                else if (stat.hops_full)
                begin
                    st_next    = ST_LONG;
                    state_next = S_SOUT;
                end
                else
                begin
                    cmd.op     = OP_TTOP;
                    state_next = S_TPAR;
                end
            end
            S_TPAR:
            begin
                cmd.op     = OP_TPAR;
                state_next = S_TOFFA;
            end
            S_TOFFA:
            begin
                cmd.op     = OP_OFFA;
                state_next = S_TOFFE;
            end
            S_TOFFE:
            begin
                cmd.op     = OP_OFFE;
                state_next = S_TSCAN;
            end
            S_TSCAN:
            begin
                if (stat.edge_more)
                begin
                    cmd.op     = OP_ESCAN;
                    state_next = S_TCHK;
                end
                else
                    state_next = S_TPUSH;
            end
            S_TCHK:
            begin
                if (stat.scan_hit)
                begin
                    cmd.op     = OP_THIT;
                    state_next = S_TPUSH;
                end
                else
                    state_next = S_TSCAN;
            end
            S_TPUSH:
            begin
                cmd.op     = OP_TPUSH;
                state_next = S_TTOP;
            end
            S_ERD:
            begin
                cmd.op     = OP_ERD;
                state_next = S_EOUT;
            end
            S_EOUT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_EOUT;
                    state_next = stat.e_zero ? S_IDLE : S_ERD;
                end
            end
            S_SOUT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_SOUT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Advance the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg    <= ST_CHAR;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

endmodule

[hdl/bplt_dp.sv]
// Datapath with graph tables, visit marks, frontier queue, label stack and output word.
`timescale 1ns / 1ps
`include "bfs_path_label_tracer_top_assert.svh"
module bplt_dp #(
    parameter int MAX_NODES = 4096,
    parameter int MAX_EDGES = 16384,
    parameter int MAX_PATH  = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bplt_pkg::in_word_t  in_data,
    input  logic                cfg_valid,
    input  logic [12:0]         cfg_data,
    input  bplt_pkg::cmd_t      cmd,
    output bplt_pkg::stat_t     stat,
    output logic                out_valid,
    input  logic                out_ready,
    output bplt_pkg::out_word_t out_data
);
    import bplt_pkg::*;

    localparam int NW  = $clog2(MAX_NODES);
    localparam int CW  = $clog2(MAX_NODES + 1);
    localparam int OAW = $clog2(MAX_NODES + 1);
    localparam int EW  = $clog2(MAX_EDGES + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int HW  = $clog2(MAX_PATH + 1);
    localparam int SAW = (MAX_PATH > 1) ? $clog2(MAX_PATH) : 1;

    // Memories
    logic [14:0]   off_mem [MAX_NODES + 1];
    logic [11:0]   et_mem  [MAX_EDGES];
    logic [7:0]    lab_mem [MAX_EDGES];
    logic [NW:0]   par_mem [MAX_NODES];
    logic [NW-1:0] fq_mem  [MAX_NODES];
    logic [7:0]    stk_mem [MAX_PATH];

    logic [14:0]   off_rd;
    logic [11:0]   et_rd;
    logic [7:0]    lab_rd;
    logic [NW:0]   par_rd;
    logic [NW-1:0] fq_rd;
    logic [7:0]    stk_rd;

    // Control and working registers
    logic [12:0]   node_count_reg;
    logic [11:0]   cur_reg;
    logic [11:0]   goal_reg;
    logic [11:0]   start_reg;
    logic [NW-1:0] clr_reg;
    logic [CW-1:0] head_reg;
    logic [CW-1:0] tail_reg;
    logic [NW-1:0] row_reg;
    logic [NW-1:0] v_reg;
    logic [NW-1:0] pt_reg;
    logic [EW-1:0] a_reg;
    logic [EW-1:0] e_reg;
    logic [7:0]    ch_reg;
    logic [HW-1:0] hops_reg;
    logic [SAW-1:0] eidx_reg;
    logic          out_valid_reg;
    out_word_t     out_data_reg;

    logic [CW-1:0]  n_live;
    logic [EW-1:0]  off_clamp;
    logic [OAW-1:0] off_ra;
    logic           off_re;
    logic [NW-1:0]  par_ra;
    logic           par_re;
    logic           par_we;
    logic [NW-1:0]  par_wa;
    logic [NW:0]    par_wd;
    logic           fq_we;
    logic [NW-1:0]  fq_wa;
    logic [NW-1:0]  fq_wd;
    logic           out_free;

    // Clamp the node count into the usable range
    always_comb
    begin
        if (node_count_reg == 13'd0)
            n_live = CW'(1);
        else if (32'(node_count_reg) > MAX_NODES)
            n_live = CW'(MAX_NODES);
        else
            n_live = CW'(node_count_reg);
    end

    // Clamp an offset read to the edge table size
    assign off_clamp = (32'(off_rd) > MAX_EDGES) ? EW'(MAX_EDGES) : EW'(off_rd);

    assign out_free = !out_valid_reg || out_ready;

    // Offset table read address
    always_comb
    begin
        case (cmd.op)
            OP_ULAT: off_ra = OAW'(fq_rd);
            OP_TPAR: off_ra = OAW'(par_rd[NW-1:0]);
            default: off_ra = OAW'(row_reg) + OAW'(1);
        endcase
        off_re = (cmd.op == OP_ULAT) || (cmd.op == OP_TPAR) || (cmd.op == OP_OFFA);
    end

    // Parent table ports
    always_comb
    begin
        par_ra = (cmd.op == OP_EV) ? NW'(et_rd) : pt_reg;
        par_re = (cmd.op == OP_EV) || (cmd.op == OP_TTOP);
        par_we = 1'b0;
        par_wa = clr_reg;
        par_wd = '0;
        case (cmd.op)
            OP_CLEAR:
            begin
                par_we = 1'b1;
            end
            OP_SEED:
            begin
                par_we = 1'b1;
                par_wa = NW'(start_reg);
                par_wd = {1'b1, NW'(start_reg)};
            end
            OP_ES:
            begin
                par_we = 1'b1;
                par_wa = v_reg;
                par_wd = {1'b1, row_reg};
            end
            default: par_we = 1'b0;
        endcase
    end

    // Frontier queue write port
    always_comb
    begin
        fq_we = 1'b0;
        fq_wa = NW'(tail_reg);
        fq_wd = v_reg;
        if (cmd.op == OP_SEED)
        begin
            fq_we = 1'b1;
            fq_wa = '0;
            fq_wd = NW'(start_reg);
        end
        else if (cmd.op == OP_ES && 32'(tail_reg) < MAX_NODES)
            fq_we = 1'b1;
    end

    // Offset table
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD && in_data.req_type == REQ_OFFSET
            && 32'(in_data.load_index) <= MAX_NODES)
            off_mem[OAW'(in_data.load_index)] <= in_data.offset_value;
        if (off_re)
            off_rd <= off_mem[off_ra];
    end

    // Edge tables
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD && in_data.req_type == REQ_EDGE
            && 32'(in_data.load_index) < MAX_EDGES)
        begin
            et_mem[EAW'(in_data.load_index)]  <= in_data.edge_target;
            lab_mem[EAW'(in_data.load_index)] <= in_data.edge_label;
        end
        if (cmd.op == OP_ESCAN)
        begin
            et_rd  <= et_mem[a_reg[EAW-1:0]];
            lab_rd <= lab_mem[a_reg[EAW-1:0]];
        end
    end

    // Visit marks and parents
    always_ff @(posedge clk)
    begin
        if (par_we)
            par_mem[par_wa] <= par_wd;
        if (par_re)
            par_rd <= par_mem[par_ra];
    end

    // Frontier queue
    always_ff @(posedge clk)
    begin
        if (fq_we)
            fq_mem[fq_wa] <= fq_wd;
        if (cmd.op == OP_DEQ)
            fq_rd <= fq_mem[NW'(head_reg)];
    end

    // Label stack
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_TPUSH)
            stk_mem[SAW'(hops_reg)] <= ch_reg;
        if (cmd.op == OP_ERD)
            stk_rd <= stk_mem[eidx_reg];
    end

    // Hold configuration, current node and output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RST;
            cur_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                node_count_reg <= cfg_data;
            if (cmd.op == OP_QLATCH)
                cur_reg <= in_data.goal_node;
            if (cmd.op == OP_EOUT || cmd.op == OP_SOUT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Advance working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_QLATCH:
            begin
                goal_reg  <= in_data.goal_node;
                start_reg <= cur_reg;
                clr_reg   <= '0;
            end
            OP_CLEAR: clr_reg <= clr_reg + NW'(1);
            OP_SEED:
            begin
                head_reg <= '0;
                tail_reg <= CW'(1);
            end
            OP_DEQ:  head_reg <= head_reg + CW'(1);
            OP_ULAT: row_reg  <= fq_rd;
            OP_OFFA: a_reg    <= off_clamp;
            OP_OFFE:
            begin
                e_reg  <= off_clamp;
                ch_reg <= '0;
            end
            OP_ESCAN: a_reg <= a_reg + EW'(1);
            OP_EV:    v_reg <= NW'(et_rd);
            OP_ES:
            begin
                if (32'(tail_reg) < MAX_NODES)
                    tail_reg <= tail_reg + CW'(1);
                pt_reg   <= NW'(goal_reg);
                hops_reg <= '0;
            end
            OP_TPAR: row_reg <= par_rd[NW-1:0];
            OP_THIT:
            begin
                ch_reg <= lab_rd;
                a_reg  <= e_reg;
            end
            OP_TPUSH:
            begin
                hops_reg <= hops_reg + HW'(1);
                pt_reg   <= row_reg;
            end
            OP_EINIT: eidx_reg <= SAW'(hops_reg - HW'(1));
            OP_EOUT:
            begin
                out_data_reg.label_char <= stk_rd;
                out_data_reg.status     <= ST_CHAR;
                out_data_reg.last       <= (eidx_reg == '0);
                eidx_reg                <= eidx_reg - SAW'(1);
            end
            OP_SOUT:
            begin
                out_data_reg.label_char <= '0;
                out_data_reg.status     <= cmd.st;
                out_data_reg.last       <= 1'b1;
            end
            default: ch_reg <= ch_reg;
        endcase
    end

    // Report status to the sequencer
    always_comb
    begin
        stat.chk_bad   = (32'(goal_reg) >= 32'(n_live)) || (32'(start_reg) >= 32'(n_live));
        stat.chk_same  = (goal_reg == start_reg);
        stat.clr_done  = (clr_reg == NW'(MAX_NODES - 1));
        stat.q_empty   = (head_reg >= tail_reg);
        stat.edge_more = (a_reg < e_reg);
        stat.v_bad     = (32'(et_rd) >= 32'(n_live));
        stat.v_seen    = par_rd[NW];
        stat.v_goal    = (32'(v_reg) == 32'(goal_reg));
        stat.at_start  = (32'(pt_reg) == 32'(start_reg));
        stat.hops_full = (32'(hops_reg) >= MAX_PATH);
        stat.scan_hit  = (32'(et_rd) == 32'(pt_reg));
        stat.e_zero    = (eidx_reg == '0);
        stat.out_free  = out_free;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `BPLT_ASSERT_NOW(a_stat_word, clk, rst_n, out_valid_reg && out_data_reg.status != ST_CHAR, out_data_reg.label_char == 8'd0 && out_data_reg.last, "status word must carry zero char and last")
    `BPLT_ASSERT_NOW(a_push_bound, clk, rst_n, cmd.op == OP_TPUSH, 32'(hops_reg) < MAX_PATH, "label stack push beyond path limit")
    `BPLT_ASSERT_NOW(a_out_load, clk, rst_n, cmd.op == OP_EOUT || cmd.op == OP_SOUT, out_free, "output word overwritten while held")
    `BPLT_ASSERT_NEXT(a_deq_order, clk, rst_n, cmd.op == OP_DEQ, head_reg <= tail_reg, "frontier head passed tail")

endmodule

[hdl/bfs_path_label_tracer_top.sv]
// Breadth-first shortest labelled path tracer: sequencer plus datapath.
// Flow: table writes are taken while idle; a query checks the goal and start nodes and clears
// the visit marks, then dequeues nodes and scans their edges, then per hop scans the parent's
// edges up to the match, then emits the characters one word each.
// One item at a time; the single-port tables (offsets, edges, parents) set the pace.
// Reset: asynchronous active low; current node 0, node count 4096, no output pending.
`timescale 1ns / 1ps
module bfs_path_label_tracer_top #(
    parameter int MAX_NODES = bplt_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = bplt_pkg::MAX_EDGES_DEF,
    parameter int MAX_PATH  = bplt_pkg::MAX_PATH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bplt_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output bplt_pkg::out_word_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [12:0]         cfg_data
);
    import bplt_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Take configuration words at any time
    assign cfg_ready = 1'b1;

    bplt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_req   (in_data.req_type),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bplt_dp #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES),
        .MAX_PATH  (MAX_PATH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

[tb/tb_bfs_path_label_tracer_top.sv]
// Self-checking testbench for the breadth-first labelled path tracer.
`timescale 1ns / 1ps
module tb_bfs_path_label_tracer_top;
    import bplt_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Tracks the graph tables and predicts the words each query should return
    class path_scoreboard;
        logic [14:0] offs [0:4096];
        bit          offs_set [0:4096];
        logic [11:0] edge_tgt [0:16383];
        logic [7:0]  edge_lab [0:16383];
        bit          edge_set [0:16383];
        int unsigned cur_node;
        int unsigned node_cnt;
        out_word_t   pending_q[$];
        int          errors;
        int          results;
        int          queries;

        function new();
            cur_node = 0;
            node_cnt = 4096;
            errors   = 0;
            results  = 0;
            queries  = 0;
        endfunction

        function void set_count(logic [12:0] v);
            node_cnt = 32'(v);
        endfunction

        function int unsigned live_nodes();
            if (node_cnt == 0) return 1;
            if (node_cnt > MAX_NODES_DEF) return MAX_NODES_DEF;
            return node_cnt;
        endfunction

        // Read an offset, clamped to the edge table, and flag never-written entries
        function int unsigned off_at(int unsigned i, ref bit clean);
            if (!offs_set[i]) clean = 0;
            if (offs[i] > MAX_EDGES_DEF) return MAX_EDGES_DEF;
            return 32'(offs[i]);
        endfunction

        function out_word_t make_word(logic [7:0] ch, logic [1:0] st, logic lst);
            out_word_t w;
            w.label_char = ch;
            w.status     = st;
            w.last       = lst;
            return w;
        endfunction

        // Search from the current node and build the result words for one goal
        function void trace_path(logic [11:0] goal, ref out_word_t res[$], ref bit clean);
            int unsigned n, start, u, v, a, e, pt, f, hops;
            bit          found;
            bit          seen[];
            int unsigned par[];
            int unsigned fifo[$];
            logic [7:0]  ch;
            logic [7:0]  chars[$];
            res.delete();
            clean = 1;
            n     = live_nodes();
            start = cur_node;
            if (goal >= n || start >= n) begin
                res.push_back(make_word(8'd0, ST_UNREACH, 1'b1));
                return;
            end
            if (goal == start) begin
                res.push_back(make_word(8'd0, ST_EMPTY, 1'b1));
                return;
            end
            seen = new[n];
            par  = new[n];
            seen[start] = 1;
            par[start]  = start;
            fifo.push_back(start);
            found = 0;
            while (fifo.size() > 0 && !found)
            begin
                u = fifo.pop_front();
                a = off_at(u, clean);
                e = off_at(u + 1, clean);
                for (; a < e; a++)
                begin
                    if (!edge_set[a]) clean = 0;
                    v = 32'(edge_tgt[a]);
                    if (v >= n || seen[v]) continue;
                    seen[v] = 1;
                    par[v]  = u;
                    fifo.push_back(v);
                    if (v == goal)
                    begin
                        found = 1;
                        break;
                    end
                end
            end
            if (!found) begin
                res.push_back(make_word(8'd0, ST_UNREACH, 1'b1));
                return;
            end
            // Walk parents back, first matching edge gives each hop's character
            pt   = 32'(goal);
            hops = 0;
            while (pt != start)
            begin
                f = par[pt];
                if (hops >= MAX_PATH_DEF) begin
                    res.delete();
                    res.push_back(make_word(8'd0, ST_LONG, 1'b1));
                    return;
                end
                a  = off_at(f, clean);
                e  = off_at(f + 1, clean);
                ch = 8'd0;
                for (; a < e; a++)
                begin
                    if (!edge_set[a]) clean = 0;
                    if (edge_tgt[a] == pt)
                    begin
                        ch = edge_lab[a];
                        break;
                    end
                end
                chars.push_front(ch);
                hops++;
                pt = f;
            end
            foreach (chars[i])
                res.push_back(make_word(chars[i], ST_CHAR, i == chars.size() - 1));
        endfunction

        // Apply an accepted input word and queue the words it should produce
        function void note_input(in_word_t w);
            out_word_t res[$];
            bit        clean;
            case (w.req_type)
                REQ_OFFSET:
                    if (w.load_index <= MAX_NODES_DEF)
                    begin
                        offs[w.load_index]     = w.offset_value;
                        offs_set[w.load_index] = 1;
                    end
                REQ_EDGE:
                    if (w.load_index < MAX_EDGES_DEF)
                    begin
                        edge_tgt[w.load_index] = w.edge_target;
                        edge_lab[w.load_index] = w.edge_label;
                        edge_set[w.load_index] = 1;
                    end
                REQ_QUERY:
                begin
                    trace_path(w.goal_node, res, clean);
                    foreach (res[i]) pending_q.push_back(res[i]);
                    cur_node = 32'(w.goal_node);
                    queries++;
                end
                default: ;
            endcase
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10) $display("[%0t] ERROR: %s", $realtime, msg);
        endfunction

        // Compare one result word with the oldest expectation
        function void check(out_word_t got);
            out_word_t exp_w;
            results++;
            if (pending_q.size() == 0) begin
                flag($sformatf("unexpected word char=%0h status=%0d last=%0d",
                               got.label_char, got.status, got.last));
                return;
            end
            exp_w = pending_q.pop_front();
            if (got.label_char !== exp_w.label_char || got.status !== exp_w.status ||
                got.last !== exp_w.last)
                flag($sformatf("exp char=%0h status=%0d last=%0d, got char=%0h status=%0d last=%0d",
                               exp_w.label_char, exp_w.status, exp_w.last,
                               got.label_char, got.status, got.last));
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_ready;
    in_word_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 0;
    out_word_t   out_data;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [12:0] cfg_data = '0;

    path_scoreboard sb = new();
    int send_gap = 31;
    int recv_gap = 61;
    int cfg_writes = 0;

    bfs_path_label_tracer_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Take result words and stall at random
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) sb.check(out_data);
        out_ready <= ($urandom_range(99) >= recv_gap);
    end

    // Drive one word, holding it until accepted; valid is left high on return
    task automatic send_word(in_word_t w);
        while ($urandom_range(99) < send_gap)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (!in_ready);
        sb.note_input(w);
    endtask

    function automatic in_word_t noise_word();
        in_word_t w;
        w = {$urandom, $urandom};
        return w;
    endfunction

    task automatic put_offset(int unsigned idx, int unsigned val);
        in_word_t w;
        w = noise_word();
        w.req_type     = REQ_OFFSET;
        w.load_index   = 15'(idx);
        w.offset_value = 15'(val);
        send_word(w);
    endtask

    task automatic put_edge(int unsigned idx, int unsigned tgt, int unsigned lab);
        in_word_t w;
        w = noise_word();
        w.req_type    = REQ_EDGE;
        w.load_index  = 15'(idx);
        w.edge_target = 12'(tgt);
        w.edge_label  = 8'(lab);
        send_word(w);
    endtask

    // Ask for a path; fall back to the current node if the goal would touch unwritten entries
    task automatic ask(logic [11:0] goal);
        in_word_t  w;
        out_word_t res[$];
        bit        clean;
        sb.trace_path(goal, res, clean);
        if (!clean) goal = 12'(sb.cur_node);
        w = noise_word();
        w.req_type  = REQ_QUERY;
        w.goal_node = goal;
        send_word(w);
    endtask

    // Hold the sender until every expected word has come, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_count(logic [12:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        sb.set_count(v);
        cfg_writes++;
        cfg_valid <= 1'b0;
    endtask

    // Build a small random graph over n nodes with its edges starting at base
    task automatic build_graph(int unsigned n, int unsigned base, output int unsigned ecount);
        int unsigned acc;
        acc = 0;
        for (int unsigned i = 0; i <= n; i++)
        begin
            put_offset(i, base + acc);
            if (i < n) acc += $urandom_range(0, 3);
        end
        ecount = acc;
        for (int unsigned i = 0; i < ecount; i++)
            put_edge(base + i, $urandom_range(0, n), $urandom_range(0, 255));
    endtask

    task automatic random_phase(int items);
        int unsigned n, base, ecount, r;
        n    = $urandom_range(4, 8);
        base = $urandom_range(0, 300);
        write_count(13'(n));
        build_graph(n, base, ecount);
        for (int k = 0; k < items; k++)
        begin
            r = $urandom_range(99);
            if (k == items / 2) drain();
            if (r < 45)
            begin
                if ($urandom_range(99) < 80) ask(12'($urandom_range(0, n - 1)));
                else ask(12'($urandom));
            end
            else if (r < 65 && ecount > 0)
            begin
                if ($urandom_range(9) == 0)
                    put_edge(base + $urandom_range(0, ecount - 1), $urandom, $urandom);
                else
                    put_edge(base + $urandom_range(0, ecount - 1), $urandom_range(0, n),
                             $urandom);
            end
            else if (r < 75)
            begin
                if ($urandom_range(9) == 0) put_offset($urandom_range(0, n), $urandom);
                else put_offset($urandom_range(0, n), base + $urandom_range(0, ecount));
            end
            else if (r < 85)
            begin
                in_word_t w;
                w = noise_word();
                w.req_type = REQ_UNUSED;
                send_word(w);
            end
            else if (r < 92) put_offset($urandom_range(4097, 32767), $urandom);
            else put_edge($urandom_range(16384, 32767), $urandom, $urandom);
        end
    endtask

    initial
    begin
        #60_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int waited;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Chain 0 -> 1 -> ... -> 65, edge i leaves node i
        for (int i = 0; i <= 65; i++) put_offset(i, i);
        put_offset(66, 65);
        put_offset(67, 65);
        for (int i = 0; i <= 64; i++)
            put_edge(i, i + 1, i == 0 ? 0 : (i == 64 ? 8'hFF : $urandom_range(0, 255)));
        // Writes past the tables are dropped
        put_offset(4097, 12);
        put_offset(32767, 32767);
        put_edge(16384, 4095, 8'hFF);
        put_edge(32767, 4095, 8'hFF);
        begin
            in_word_t w;
            w = noise_word();
            w.req_type = REQ_UNUSED;
            send_word(w);
        end
        // Last node with clamped, empty edge range
        put_offset(4095, 20000);
        put_offset(4096, 32767);
        ask(0);
        ask(64);
        ask(0);
        ask(65);
        ask(4095);
        ask(0);
        // Count of zero acts as one node
        write_count(13'd0);
        ask(0);
        ask(0);
        ask(4095);
        write_count(13'd8191);
        ask(3);
        write_count(13'd4096);
        ask(1);
        // Edge 4 -> 5 is skipped once only five nodes are in use
        write_count(13'd5);
        ask(4);
        ask(0);
        ask(5);

        send_gap = 31; recv_gap = 61;
        random_phase(10);
        send_gap = 61; recv_gap = 31;
        random_phase(10);
        send_gap = 0; recv_gap = 0;
        random_phase(10);
        write_count(13'd1);
        ask(0);

        in_valid <= 1'b0;
        waited = 0;
        while (sb.pending_q.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (200) @(posedge clk);
        if (sb.pending_q.size() != 0)
            sb.flag($sformatf("%0d expected words never arrived", sb.pending_q.size()));
        $display("Ran %0d path queries over chain and random graphs, %0d result words.",
                 sb.queries, sb.results);
        $display("Node count written %0d times, including zero, one and above the limit.",
                 cfg_writes);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

[filelist.f]
+incdir+hdl
hdl/bplt_pkg.sv
hdl/bplt_ctrl.sv
hdl/bplt_dp.sv
hdl/bfs_path_label_tracer_top.sv
tb/tb_bfs_path_label_tracer_top.sv
